>>> src/epsilon_closure_engine_macros.svh
// Assertion shorthands used by the checker of the closure engine.
`ifndef EPSILON_CLOSURE_ENGINE_MACROS_SVH
`define EPSILON_CLOSURE_ENGINE_MACROS_SVH

// Same-cycle implication, clocked on clock and disabled while reset is high.
`define ECE_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, clocked on clock and disabled while reset is high.
`define ECE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/ece_pkg.sv
package ece_pkg;

   localparam int STATE_W        = 5;
   localparam int SYMBOL_W       = 8;
   localparam int OP_W           = 2;
   localparam int MASK_W         = 32;
   localparam int DEFAULT_STATES = 32;
   localparam int MAX_ROWS       = 32;

   localparam logic [SYMBOL_W-1:0] EPSILON_SYMBOL = 8'd101;

   typedef enum logic [OP_W-1:0] {
      OP_CLEAR = 2'd0,
      OP_ADD   = 2'd1,
      OP_QUERY = 2'd2
   } op_type;

   // Operation carried by a token as it walks down the cell chain.
   typedef enum logic [1:0] {
      TOK_CLEAR  = 2'd0,
      TOK_READ   = 2'd1,
      TOK_UPDATE = 2'd2
   } tok_op_type;

   typedef struct packed {
      logic               valid;
      tok_op_type         op;
      logic [STATE_W-1:0] key;
   } token_type;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'd0,
      ST_READ  = 3'd1,
      ST_BUSY  = 3'd2,
      ST_QUERY = 3'd3,
      ST_HOLD  = 3'd4
   } state_type;

endpackage

>>> src/ece_cell.sv
module ece_cell #(
   parameter int ROWS  = ece_pkg::MAX_ROWS,
   parameter int INDEX = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ece_pkg::token_type   up_tok,
   input  logic [ROWS-1:0]      up_data,
   output ece_pkg::token_type   dn_tok,
   output logic [ROWS-1:0]      dn_data
);

   localparam int IW = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam logic [ece_pkg::STATE_W-1:0] MY_KEY = ece_pkg::STATE_W'(INDEX);

   // row_ff holds the closure row of state INDEX: every state it reaches
   // over one or more epsilon edges.
   logic [ROWS-1:0]    row_ff;
   logic [ROWS-1:0]    row_in;
   ece_pkg::token_type tok_ff;
   logic [ROWS-1:0]    data_ff;
   logic [ROWS-1:0]    data_in;
   logic               hit;

   always_comb begin
      hit     = (up_tok.key == MY_KEY);
      row_in  = row_ff;
      data_in = up_data;
      if (up_tok.valid) begin
         case (up_tok.op)
            ece_pkg::TOK_CLEAR: begin
               row_in = '0;
            end
            ece_pkg::TOK_READ: begin
               if (hit) begin
                  data_in = row_ff;
               end
            end
            ece_pkg::TOK_UPDATE: begin
               // A state that is the edge source, or already reaches it,
               // now also reaches everything the destination carries.
               if (hit || row_ff[up_tok.key[IW-1:0]]) begin
                  row_in = row_ff | up_data;
               end
            end
            default: begin
               row_in = row_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         tok_ff <= '0;
      end else begin
         row_ff <= row_in;
         tok_ff <= up_tok;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign dn_tok  = tok_ff;
   assign dn_data = data_ff;

endmodule

>>> src/ece_chain.sv
module ece_chain #(
   parameter int ROWS = ece_pkg::MAX_ROWS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ece_pkg::token_type   head_tok,
   input  logic [ROWS-1:0]      head_data,
   output ece_pkg::token_type   tail_tok,
   output logic [ROWS-1:0]      tail_data
);

   ece_pkg::token_type tok_line [ROWS+1];
   logic [ROWS-1:0]    data_line [ROWS+1];

   assign tok_line[0]  = head_tok;
   assign data_line[0] = head_data;

   for (genvar g = 0; g < ROWS; g++) begin : g_cell
      ece_cell #(
         .ROWS  (ROWS),
         .INDEX (g)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .up_tok  (tok_line[g]),
         .up_data (data_line[g]),
         .dn_tok  (tok_line[g+1]),
         .dn_data (data_line[g+1])
      );
   end

   assign tail_tok  = tok_line[ROWS];
   assign tail_data = data_line[ROWS];

endmodule

>>> src/epsilon_closure_engine.sv
// Epsilon-closure engine: keeps the reachability closure of an NFA's epsilon graph in a chain
// of min(STATES, 32) cells, one closure row per cell, and answers a query with the set of
// states reachable from the queried state, the state itself included. A clear or an in-range
// query sends one token down the chain, one cell per cycle, and an epsilon add-edge sends two
// in turn: a read pass fetches the destination's row, and an update pass merges it into the
// source's row and every row that reaches the source. An ignored item and a query of a state
// at or above STATES send no token; such a query answers with an empty mask. The block takes
// one transaction at a time; a finished result waits in the output register while the next
// transaction is accepted, and a new result that finds that register still stalled holds the
// block until the older one is taken.
module epsilon_closure_engine #(
   parameter int STATES = ece_pkg::DEFAULT_STATES
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [ece_pkg::OP_W-1:0]      req_operation,
   input  logic [ece_pkg::STATE_W-1:0]   req_from_state,
   input  logic [ece_pkg::STATE_W-1:0]   req_to_state,
   input  logic [ece_pkg::SYMBOL_W-1:0]  req_symbol_code,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [ece_pkg::STATE_W-1:0]   rsp_queried_state,
   output logic [ece_pkg::MASK_W-1:0]    rsp_closure_mask
);

   localparam int ROWS = (STATES < ece_pkg::MAX_ROWS) ? STATES : ece_pkg::MAX_ROWS;
   localparam int IW   = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam logic [ece_pkg::STATE_W:0] ROWS_LIM = (ece_pkg::STATE_W + 1)'(ROWS);

   ece_pkg::state_type            state_ff;
   ece_pkg::state_type            state_in;
   ece_pkg::token_type            launch_ff;
   ece_pkg::token_type            launch_in;
   logic [ROWS-1:0]               launch_data_ff;
   logic [ROWS-1:0]               launch_data_in;
   logic [ece_pkg::STATE_W-1:0]   from_ff;
   logic [ece_pkg::STATE_W-1:0]   to_ff;
   logic [ece_pkg::MASK_W-1:0]    hold_mask_ff;
   logic [ece_pkg::MASK_W-1:0]    hold_mask_in;
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic [ece_pkg::STATE_W-1:0]   rsp_state_ff;
   logic [ece_pkg::MASK_W-1:0]    rsp_mask_ff;

   ece_pkg::token_type            tail_tok;
   logic [ROWS-1:0]               tail_data;
   logic                          req_accept;
   logic                          out_free;
   logic                          out_load;
   logic                          from_ok;
   logic                          to_ok;
   logic [ROWS-1:0]               from_bit;
   logic [ROWS-1:0]               to_bit;

   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign from_ok    = ({1'b0, req_from_state} < ROWS_LIM);
   assign to_ok      = ({1'b0, req_to_state} < ROWS_LIM);
   assign from_bit   = ROWS'(1) << from_ff[IW-1:0];
   assign to_bit     = ROWS'(1) << to_ff[IW-1:0];

   always_comb begin
      state_in       = state_ff;
      launch_in      = '0;
      launch_data_in = '0;
      hold_mask_in   = hold_mask_ff;
      out_load       = 1'b0;
      req_stall      = 1'b1;
      case (state_ff)
         ece_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               case (ece_pkg::op_type'(req_operation))
                  ece_pkg::OP_CLEAR: begin
                     launch_in.valid = 1'b1;
                     launch_in.op    = ece_pkg::TOK_CLEAR;
                     state_in        = ece_pkg::ST_BUSY;
                  end
                  ece_pkg::OP_ADD: begin
                     // The destination's row is fetched first; the update
                     // pass needs it before any row changes.
                     if (req_symbol_code == ece_pkg::EPSILON_SYMBOL && from_ok && to_ok) begin
                        launch_in.valid = 1'b1;
                        launch_in.op    = ece_pkg::TOK_READ;
                        launch_in.key   = req_to_state;
                        state_in        = ece_pkg::ST_READ;
                     end
                  end
                  ece_pkg::OP_QUERY: begin
                     if (from_ok) begin
                        launch_in.valid = 1'b1;
                        launch_in.op    = ece_pkg::TOK_READ;
                        launch_in.key   = req_from_state;
                        state_in        = ece_pkg::ST_QUERY;
                     end else begin
                        hold_mask_in = '0;
                        state_in     = ece_pkg::ST_HOLD;
                     end
                  end
                  default: begin
                     state_in = ece_pkg::ST_IDLE;
                  end
               endcase
            end
         end
         ece_pkg::ST_READ: begin
            if (tail_tok.valid) begin
               launch_in.valid = 1'b1;
               launch_in.op    = ece_pkg::TOK_UPDATE;
               launch_in.key   = from_ff;
               launch_data_in  = tail_data | to_bit;
               state_in        = ece_pkg::ST_BUSY;
            end
         end
         ece_pkg::ST_BUSY: begin
            if (tail_tok.valid) begin
               state_in = ece_pkg::ST_IDLE;
            end
         end
         ece_pkg::ST_QUERY: begin
            if (tail_tok.valid) begin
               hold_mask_in = ece_pkg::MASK_W'(tail_data | from_bit);
               state_in     = ece_pkg::ST_HOLD;
            end
         end
         ece_pkg::ST_HOLD: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = ece_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ece_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ece_pkg::ST_IDLE;
         launch_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         launch_ff    <= launch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      launch_data_ff <= launch_data_in;
      hold_mask_ff   <= hold_mask_in;
      if (req_accept) begin
         from_ff <= req_from_state;
         to_ff   <= req_to_state;
      end
      if (out_load) begin
         rsp_state_ff <= from_ff;
         rsp_mask_ff  <= hold_mask_ff;
      end
   end

   ece_chain #(
      .ROWS (ROWS)
   ) u_chain (
      .clock     (clock),
      .reset     (reset),
      .head_tok  (launch_ff),
      .head_data (launch_data_ff),
      .tail_tok  (tail_tok),
      .tail_data (tail_data)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_queried_state = rsp_state_ff;
   assign rsp_closure_mask  = rsp_mask_ff;

endmodule

>>> src/ece_checker.sv
`include "epsilon_closure_engine_macros.svh"

module ece_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic [ece_pkg::OP_W-1:0]      req_operation,
   input logic [ece_pkg::STATE_W-1:0]   req_from_state,
   input logic [ece_pkg::STATE_W-1:0]   req_to_state,
   input logic [ece_pkg::SYMBOL_W-1:0]  req_symbol_code,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [ece_pkg::STATE_W-1:0]   rsp_queried_state,
   input logic [ece_pkg::MASK_W-1:0]    rsp_closure_mask
);

   // A stalled result transaction keeps its payload.
   `ECE_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_closure_mask) && $stable(rsp_queried_state), "stalled result changed")

   // A non-empty closure always contains the queried state itself.
   `ECE_ASSERT_NOW(a_self_member, rsp_valid && (rsp_closure_mask != '0), ((rsp_closure_mask >> rsp_queried_state) & 32'd1) == 32'd1, "closure misses its own state")

   // A clear walks the whole cell chain, so the block is busy right after it.
   `ECE_ASSERT_NEXT(a_clear_busy, req_valid && !req_stall && (req_operation == ece_pkg::OP_CLEAR), req_stall, "clear did not occupy the chain")

   // Only a query can produce a result.
   `ECE_ASSERT_NEXT(a_no_spurious_rsp, req_valid && !req_stall && (req_operation != ece_pkg::OP_QUERY) && !rsp_valid, !rsp_valid, "result without a query")

endmodule

bind epsilon_closure_engine ece_checker u_ece_checker (.*);

>>> tb/closure_checker.sv
module closure_checker #(
   parameter int STATES = ece_pkg::DEFAULT_STATES
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic [ece_pkg::OP_W-1:0]      req_operation,
   input  logic [ece_pkg::STATE_W-1:0]   req_from_state,
   input  logic [ece_pkg::STATE_W-1:0]   req_to_state,
   input  logic [ece_pkg::SYMBOL_W-1:0]  req_symbol_code,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [ece_pkg::STATE_W-1:0]   rsp_queried_state,
   input  logic [ece_pkg::MASK_W-1:0]    rsp_closure_mask,
   output int                            failures,
   output int                            outstanding
);

   // Watches both channels of the closure engine, keeps its own copy of the epsilon graph,
   // predicts the closure for every accepted query and compares it with the returned result.

   typedef struct packed {
      logic [ece_pkg::STATE_W-1:0] state;
      logic [ece_pkg::MASK_W-1:0]  mask;
   } closure_type;

   logic [ece_pkg::MASK_W-1:0] edge_rows [ece_pkg::MAX_ROWS];
   closure_type                closures_due [$];

   initial begin
      failures = 0;
      outstanding = 0;
   end

   task automatic report(input string what);
      $display("ERROR at %0t: %s", $time, what);
      failures++;
   endtask

   function automatic bit state_exists(input logic [ece_pkg::STATE_W-1:0] s);
      return int'(s) < STATES && int'(s) < ece_pkg::MAX_ROWS;
   endfunction

   // Breadth of the search follows the lowest pending state first; the order does not
   // change the final set.
   function automatic logic [ece_pkg::MASK_W-1:0] reach_from(
      input logic [ece_pkg::STATE_W-1:0] start);
      logic [ece_pkg::MASK_W-1:0] reached;
      logic [ece_pkg::MASK_W-1:0] frontier;
      logic [ece_pkg::MASK_W-1:0] legal;
      logic [ece_pkg::MASK_W-1:0] fresh;
      int s;
      legal = (STATES >= ece_pkg::MASK_W) ? {ece_pkg::MASK_W{1'b1}}
                                          : ((ece_pkg::MASK_W'(1) << STATES) - 1'b1);
      reached = '0;
      reached[start] = 1'b1;
      frontier = reached;
      while (frontier != '0) begin
         for (s = 0; s < ece_pkg::MASK_W - 1; s++) begin
            if (frontier[s]) break;
         end
         frontier[s] = 1'b0;
         fresh = edge_rows[s] & legal & ~reached;
         reached |= fresh;
         frontier |= fresh;
      end
      return reached;
   endfunction

   always @(posedge clock) begin
      closure_type due;
      closure_type want;
      if (reset) begin
         foreach (edge_rows[i]) edge_rows[i] = '0;
         closures_due.delete();
      end else begin
         // Results are checked before the new request is applied, so a stray result can
         // never be matched against a query accepted in the same cycle.
         if (rsp_valid && !rsp_stall) begin
            if (closures_due.size() == 0) begin
               report($sformatf("unexpected result: state %0d mask %h",
                                rsp_queried_state, rsp_closure_mask));
            end else begin
               want = closures_due.pop_front();
               if (rsp_queried_state !== want.state)
                  report($sformatf("queried_state %0d, expected %0d",
                                   rsp_queried_state, want.state));
               if (rsp_closure_mask !== want.mask)
                  report($sformatf("closure of state %0d: mask %h, expected %h",
                                   want.state, rsp_closure_mask, want.mask));
            end
         end
         if (req_valid && !req_stall) begin
            case (req_operation)
               ece_pkg::OP_CLEAR: begin
                  foreach (edge_rows[i]) edge_rows[i] = '0;
               end
               ece_pkg::OP_ADD: begin
                  if (req_symbol_code == ece_pkg::EPSILON_SYMBOL
                      && state_exists(req_from_state) && state_exists(req_to_state))
                     edge_rows[req_from_state][req_to_state] = 1'b1;
               end
               ece_pkg::OP_QUERY: begin
                  due.state = req_from_state;
                  due.mask = state_exists(req_from_state) ? reach_from(req_from_state) : '0;
                  closures_due.push_back(due);
               end
               default: begin
               end
            endcase
         end
      end
      outstanding <= closures_due.size();
   end

   final begin
      if (closures_due.size() != 0)
         $display("ERROR: %0d closure results never arrived", closures_due.size());
   end

endmodule

>>> tb/tb.sv
module tb;

   localparam int STATES = ece_pkg::DEFAULT_STATES;
   localparam int ITEM_TARGET = 1150;
   localparam int CALM_TAIL = 150;
   localparam logic [ece_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic [ece_pkg::OP_W-1:0]      req_operation;
   logic [ece_pkg::STATE_W-1:0]   req_from_state;
   logic [ece_pkg::STATE_W-1:0]   req_to_state;
   logic [ece_pkg::SYMBOL_W-1:0]  req_symbol_code;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic [ece_pkg::STATE_W-1:0]   rsp_queried_state;
   logic [ece_pkg::MASK_W-1:0]    rsp_closure_mask;

   int  failures;
   int  outstanding;
   logic idle_on;
   int  stall_left;
   int  clears_sent, edges_sent, queries_sent, ignored_sent;

   epsilon_closure_engine #(.STATES(STATES)) DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_from_state    (req_from_state),
      .req_to_state      (req_to_state),
      .req_symbol_code   (req_symbol_code),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_queried_state (rsp_queried_state),
      .rsp_closure_mask  (rsp_closure_mask)
   );

   closure_checker #(.STATES(STATES)) u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_from_state    (req_from_state),
      .req_to_state      (req_to_state),
      .req_symbol_code   (req_symbol_code),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_queried_state (rsp_queried_state),
      .rsp_closure_mask  (rsp_closure_mask),
      .failures          (failures),
      .outstanding       (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("Timeout with %0d closure results still outstanding", outstanding);
      $display("simulation failed");
      $finish;
   end

   // Result-side backpressure comes in bursts of random length while idling is enabled.
   always @(posedge clock) begin
      if (reset || !idle_on) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 7) == 0) begin
         rsp_stall <= 1'b1;
         stall_left <= $urandom_range(0, 11);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   function automatic logic [ece_pkg::STATE_W-1:0] rnd_state();
      return ece_pkg::STATE_W'($urandom);
   endfunction

   function automatic logic [ece_pkg::SYMBOL_W-1:0] rnd_symbol();
      return ece_pkg::SYMBOL_W'($urandom);
   endfunction

   function automatic int items_sent();
      return clears_sent + edges_sent + queries_sent + ignored_sent;
   endfunction

   task automatic send(input logic [ece_pkg::OP_W-1:0] op,
                       input logic [ece_pkg::STATE_W-1:0] from_s,
                       input logic [ece_pkg::STATE_W-1:0] to_s,
                       input logic [ece_pkg::SYMBOL_W-1:0] sym);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_from_state <= from_s;
      req_to_state <= to_s;
      req_symbol_code <= sym;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      case (op)
         ece_pkg::OP_CLEAR: clears_sent++;
         ece_pkg::OP_ADD:   if (sym == ece_pkg::EPSILON_SYMBOL) edges_sent++;
                            else ignored_sent++;
         ece_pkg::OP_QUERY: queries_sent++;
         default:           ignored_sent++;
      endcase
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   initial begin
      logic [ece_pkg::STATE_W-1:0] base;
      logic [ece_pkg::STATE_W-1:0] a;
      logic [ece_pkg::STATE_W-1:0] b;
      logic [ece_pkg::SYMBOL_W-1:0] sym;
      int span;
      int seg_len;
      int pick;

      reset <= 1'b1;
      req_valid <= 1'b0;
      req_operation <= ece_pkg::OP_CLEAR;
      req_from_state <= '0;
      req_to_state <= '0;
      req_symbol_code <= '0;
      idle_on <= 1'b0;
      clears_sent = 0;
      edges_sent = 0;
      queries_sent = 0;
      ignored_sent = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty graph, a cycle, a self edge, non-epsilon symbols, a duplicate edge,
      // the unused operation code and a clear.
      send(ece_pkg::OP_QUERY, 5'd0, 5'd0, 8'd0);
      send(ece_pkg::OP_QUERY, 5'd31, 5'd31, 8'd255);
      send(ece_pkg::OP_ADD, 5'd0, 5'd1, ece_pkg::EPSILON_SYMBOL);
      send(ece_pkg::OP_ADD, 5'd1, 5'd2, ece_pkg::EPSILON_SYMBOL);
      send(ece_pkg::OP_ADD, 5'd2, 5'd0, ece_pkg::EPSILON_SYMBOL);
      send(ece_pkg::OP_ADD, 5'd2, 5'd31, ece_pkg::EPSILON_SYMBOL);
      send(ece_pkg::OP_ADD, 5'd31, 5'd30, 8'd0);
      send(ece_pkg::OP_ADD, 5'd31, 5'd30, 8'd100);
      send(ece_pkg::OP_ADD, 5'd31, 5'd30, 8'd102);
      send(ece_pkg::OP_ADD, 5'd31, 5'd30, 8'd255);
      send(ece_pkg::OP_ADD, 5'd5, 5'd5, ece_pkg::EPSILON_SYMBOL);
      send(ece_pkg::OP_ADD, 5'd0, 5'd1, ece_pkg::EPSILON_SYMBOL);
      send(ece_pkg::OP_QUERY, 5'd0, 5'd31, 8'd255);
      send(ece_pkg::OP_QUERY, 5'd1, 5'd0, 8'd0);
      send(ece_pkg::OP_QUERY, 5'd5, 5'd0, 8'd0);
      send(ece_pkg::OP_QUERY, 5'd31, 5'd0, 8'd0);
      send(ece_pkg::OP_ADD, 5'd31, 5'd0, ece_pkg::EPSILON_SYMBOL);
      send(ece_pkg::OP_QUERY, 5'd31, 5'd0, 8'd0);
      send(OP_UNUSED, 5'd31, 5'd31, 8'd255);
      send(OP_UNUSED, 5'd0, 5'd0, 8'd0);
      send(ece_pkg::OP_CLEAR, 5'd31, 5'd31, 8'd255);
      send(ece_pkg::OP_QUERY, 5'd0, 5'd0, 8'd0);
      send(ece_pkg::OP_QUERY, 5'd31, 5'd0, 8'd0);
      drain();

      // Random segments: each starts from an empty graph and builds edges from a window
      // of states, often as chains, so that closures range from one state to many.
      while (items_sent() < ITEM_TARGET) begin
         idle_on <= (items_sent() < ITEM_TARGET - CALM_TAIL) && ($urandom_range(0, 3) != 0);
         base = ece_pkg::STATE_W'($urandom_range(0, 31));
         span = $urandom_range(2, 32);
         seg_len = $urandom_range(15, 60);
         send(ece_pkg::OP_CLEAR, rnd_state(), rnd_state(), rnd_symbol());
         repeat (seg_len) begin
            a = base + ece_pkg::STATE_W'($urandom_range(0, span - 1));
            b = ($urandom_range(0, 1) == 0) ? a + ece_pkg::STATE_W'($urandom_range(1, 3))
                : base + ece_pkg::STATE_W'($urandom_range(0, span - 1));
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
               send(ece_pkg::OP_ADD, a, b, ece_pkg::EPSILON_SYMBOL);
            end else if (pick < 54) begin
               sym = rnd_symbol();
               send(ece_pkg::OP_ADD, a, b, sym);
            end else if (pick < 92) begin
               if ($urandom_range(0, 9) < 3) a = rnd_state();
               send(ece_pkg::OP_QUERY, a, rnd_state(), rnd_symbol());
            end else if (pick < 96) begin
               send(OP_UNUSED, rnd_state(), rnd_state(), rnd_symbol());
            end else begin
               send(ece_pkg::OP_CLEAR, rnd_state(), rnd_state(), rnd_symbol());
            end
         end
      end

      drain();
      // An epsilon add walks the chain twice, so let any work finish.
      repeat (100) @(posedge clock);
      $display("Sent %0d clears, %0d epsilon edges and %0d closure queries.",
               clears_sent, edges_sent, queries_sent);
      $display("Also %0d ignored transactions, with random sender gaps and result stalls.",
               ignored_sent);
      if (failures == 0 && outstanding == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
